// ===== rtl/psaru_pkg.sv =====
// Package for the video processor scroll and address register unit.
// Holds the event and result payload types, the event and register codes,
// and the fixed constants. No dependencies.
package psaru_pkg;

  // Event kinds carried in the action field of an input transfer.
  typedef enum logic [2:0] {
    ACT_REG_WRITE = 3'd0,
    ACT_REG_READ  = 3'd1,
    ACT_INC_X     = 3'd2,
    ACT_INC_Y     = 3'd3,
    ACT_COPY_H    = 3'd4,
    ACT_COPY_V    = 3'd5,
    ACT_VBLANK    = 3'd6,
    ACT_PRERENDER = 3'd7
  } action_e;

  // Processor-visible register indexes.
  typedef enum logic [2:0] {
    REG_CONTROL  = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDRESS  = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

  localparam int unsigned AddrWidth   = 16;
  localparam int unsigned MemAddrBits = 14;

  // Data port steps, palette region and Y wrap points.
  localparam logic [AddrWidth-1:0] DataIncRow  = 16'd32;
  localparam logic [AddrWidth-1:0] DataIncOne  = 16'd1;
  localparam logic [AddrWidth-1:0] FineYStep   = 16'h1000;
  localparam logic [5:0]           PaletteHigh = 6'h3F;
  localparam logic [4:0]           CoarseMax   = 5'd31;
  localparam logic [4:0]           CoarseYLast = 5'd29;
  localparam logic [2:0]           FineYMax    = 3'd7;

  typedef struct packed {
    action_e    action;
    reg_e       reg_index;
    logic [7:0] write_data;
    logic [7:0] vram_read_data;
  } psaru_in_t;

  typedef struct packed {
    logic [7:0]             read_data;
    logic [MemAddrBits-1:0] mem_address;
    logic                   mem_write;
    logic [7:0]             mem_write_data;
    logic                   mem_read;
    logic                   nmi_pulse;
    logic [2:0]             fine_x_scroll;
  } psaru_out_t;

endpackage

// ===== rtl/psaru_core.sv =====
// Architectural state of the scroll and address unit and the combinational
// event logic that updates it. Depends on psaru_pkg.
module psaru_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  psaru_pkg::psaru_in_t  event_i,
  output psaru_pkg::psaru_out_t result_o
);
  import psaru_pkg::*;

  logic [7:0]           ctrl_q, ctrl_d;
  logic [7:0]           mask_q, mask_d;
  logic                 vbl_q, vbl_d;
  logic [AddrWidth-1:0] v_q, v_d;
  logic [AddrWidth-1:0] t_q, t_d;
  logic [2:0]           fx_q, fx_d;
  logic                 w_q, w_d;
  logic [7:0]           rb_q, rb_d;

  logic                 render;
  logic [AddrWidth-1:0] v_step;
  logic [4:0]           cy;
  logic [4:0]           cy_next;
  logic                 cy_flip;

  assign render = mask_q[3] | mask_q[4];
  assign v_step = v_q + (ctrl_q[2] ? DataIncRow : DataIncOne);
  assign cy     = v_q[9:5];

  // Coarse Y wraps at the last visible row (toggling nametable Y) and also,
  // without a toggle, when it sits at the last attribute row.
  always_comb begin
    cy_flip = 1'b0;
    if (cy == CoarseYLast) begin
      cy_next = '0;
      cy_flip = 1'b1;
    end else if (cy == CoarseMax) begin
      cy_next = '0;
    end else begin
      cy_next = cy + 5'd1;
    end
  end

  always_comb begin
    ctrl_d = ctrl_q;
    mask_d = mask_q;
    vbl_d  = vbl_q;
    v_d    = v_q;
    t_d    = t_q;
    fx_d   = fx_q;
    w_d    = w_q;
    rb_d   = rb_q;

    result_o             = '0;
    result_o.mem_address = v_q[MemAddrBits-1:0];

    unique case (event_i.action)
      ACT_REG_WRITE: begin
        unique case (event_i.reg_index)
          REG_CONTROL: begin
            ctrl_d = event_i.write_data;
            t_d    = {t_q[15:12], event_i.write_data[1:0], t_q[9:0]};
          end
          REG_MASK: begin
            mask_d = event_i.write_data;
          end
          REG_SCROLL: begin
            if (!w_q) begin
              fx_d = event_i.write_data[2:0];
              t_d  = {t_q[15:5], event_i.write_data[7:3]};
              w_d  = 1'b1;
            end else begin
              t_d = {t_q[15], event_i.write_data[2:0], t_q[11:10],
                     event_i.write_data[7:3], t_q[4:0]};
              w_d = 1'b0;
            end
          end
          REG_ADDRESS: begin
            if (!w_q) begin
              t_d = {2'b00, event_i.write_data[5:0], t_q[7:0]};
              w_d = 1'b1;
            end else begin
              t_d = {t_q[15:8], event_i.write_data};
              v_d = {t_q[15:8], event_i.write_data};
              w_d = 1'b0;
            end
          end
          REG_DATA: begin
            result_o.mem_write      = 1'b1;
            result_o.mem_write_data = event_i.write_data;
            v_d                     = v_step;
          end
          default: begin
          end
        endcase
      end
      ACT_REG_READ: begin
        unique case (event_i.reg_index)
          REG_STATUS: begin
            result_o.read_data = {vbl_q, 2'b00, rb_q[4:0]};
            vbl_d              = 1'b0;
            w_d                = 1'b0;
          end
          REG_DATA: begin
            // Palette reads bypass the buffer.
            result_o.read_data = (v_q[13:8] == PaletteHigh) ? event_i.vram_read_data : rb_q;
            result_o.mem_read  = 1'b1;
            rb_d               = event_i.vram_read_data;
            v_d                = v_step;
          end
          default: begin
          end
        endcase
      end
      ACT_INC_X: begin
        if (render) begin
          if (v_q[4:0] == CoarseMax) begin
            v_d = {v_q[15:11], ~v_q[10], v_q[9:5], 5'd0};
          end else begin
            v_d = v_q + DataIncOne;
          end
        end
      end
      ACT_INC_Y: begin
        if (render) begin
          if (v_q[14:12] != FineYMax) begin
            v_d = v_q + FineYStep;
          end else begin
            v_d = {v_q[15], 3'b000, v_q[11] ^ cy_flip, v_q[10], cy_next, v_q[4:0]};
          end
        end
      end
      ACT_COPY_H: begin
        if (render) begin
          v_d = {v_q[15:11], t_q[10], v_q[9:5], t_q[4:0]};
        end
      end
      ACT_COPY_V: begin
        if (render) begin
          v_d = {v_q[15], t_q[14:11], v_q[10], t_q[9:5], v_q[4:0]};
        end
      end
      ACT_VBLANK: begin
        vbl_d              = 1'b1;
        result_o.nmi_pulse = ctrl_q[7];
      end
      ACT_PRERENDER: begin
        vbl_d = 1'b0;
      end
      default: begin
      end
    endcase

    result_o.fine_x_scroll = fx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      mask_q <= '0;
      vbl_q  <= 1'b0;
      v_q    <= '0;
      t_q    <= '0;
      fx_q   <= '0;
      w_q    <= 1'b0;
      rb_q   <= '0;
    end else if (fire_i) begin
      ctrl_q <= ctrl_d;
      mask_q <= mask_d;
      vbl_q  <= vbl_d;
      v_q    <= v_d;
      t_q    <= t_d;
      fx_q   <= fx_d;
      w_q    <= w_d;
      rb_q   <= rb_d;
    end
  end

endmodule

// ===== rtl/ppu_scroll_address_register_unit_top.sv =====
// Top level of the video processor scroll and address register unit.
// Holds the input and result registers and the transfer control; the state
// and event logic live in psaru_core. Depends on psaru_pkg and psaru_core.
//
//   Channel | Signals                         | Payload
//   --------+---------------------------------+------------------------------
//   input   | in_valid_i / in_ready_o         | in_item_i  (psaru_in_t)
//   result  | out_valid_o / out_ready_i       | out_item_o (psaru_out_t)
//
// Every input transfer produces exactly one result transfer, in order.
// The unit sustains one event per clock cycle when the result side does not
// stall. An event is first captured in the input register; once the output
// register is free, its effect on the state registers and its result are
// computed together and the result lands in the output register.
// Reset clears the architectural state and both pipeline valid bits; the
// input and output payload registers are not reset. When the result
// side stalls, the output register holds and the input register fills; the
// input side then stalls too, and nothing is lost or reordered.
module ppu_scroll_address_register_unit_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  psaru_pkg::psaru_in_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output psaru_pkg::psaru_out_t out_item_o
);
  import psaru_pkg::*;

  logic       s1_valid_q;
  psaru_in_t  s1_item_q;
  logic       out_valid_q;
  psaru_out_t out_item_q;
  psaru_out_t result;
  logic       out_free;
  logic       s1_fire;

  // The output register can take a new result when it is empty or its
  // current result is being transferred this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  // The event in the input register is executed (state committed) exactly
  // when its result moves into the output register.
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  psaru_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .event_i  (s1_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An accepted event is always held in the input register next cycle.
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted event was not captured");

  // With both stages empty the unit must be ready.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q && !out_valid_q |-> in_ready_o)
    else $error("unit not ready while empty");

  // A single event never both writes and reads video memory.
  a_one_mem_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.mem_write && out_item_o.mem_read))
    else $error("memory write and read in one result");

  // An NMI comes only from vblank start, which makes no bus activity.
  a_nmi_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.nmi_pulse |->
      !out_item_o.mem_write && !out_item_o.mem_read && (out_item_o.read_data == 8'd0))
    else $error("NMI pulse together with bus activity");

endmodule

// ===== tb/ppu_scroll_address_register_unit_top_test.sv =====
// Self-checking testbench for ppu_scroll_address_register_unit_top; depends on it
// and on psaru_pkg. Drives scroll, address and register events through the
// valid/ready channels and checks every result against a built-in predictor.
`timescale 1ns / 100ps

module ppu_scroll_address_register_unit_top_test;
  import psaru_pkg::*;

  // Traffic shapes applied one after another over the run.
  typedef enum int {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_PRESSURE,
    PH_BOTH
  } phase_e;

  // Cycles without any transfer, while work is outstanding, before giving up.
  localparam int unsigned StallLimit = 2000;
  // Wait at the end of the run for any stray result from the input and result registers.
  localparam int unsigned DrainCycles = 8;
  // Receiver hold-off pattern in the pressure phase: ready is low while the
  // position within each HoldPeriod is below HoldOff.
  localparam int unsigned HoldOff = 60;
  localparam int unsigned HoldPeriod = 100;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  psaru_in_t  in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  psaru_out_t out_item_o;

  ppu_scroll_address_register_unit_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Events waiting to be driven, and results the block still owes us.
  psaru_in_t  event_q[$];
  psaru_out_t result_q[$];

  phase_e      phase = PH_STEADY;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned events_queued = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_count = 0;

  // Predictor copy of the register state. Address layout: bits 4:0 coarse X,
  // 9:5 coarse Y, 10 nametable X, 11 nametable Y, 14:12 fine Y.
  logic [7:0]  ctrl_reg = '0;
  logic [7:0]  mask_reg = '0;
  logic        vblank_flag = 1'b0;
  logic [15:0] vaddr_cur = '0;
  logic [15:0] vaddr_tmp = '0;
  logic [2:0]  fine_x = '0;
  logic        wr_toggle = 1'b0;
  logic [7:0]  read_buf = '0;

  // Applies one event to the predictor state and returns the result it owes.
  function automatic psaru_out_t predict_event(psaru_in_t ev);
    psaru_out_t  res;
    logic [4:0]  cy;
    logic [15:0] port_step;
    logic        rendering;
    res = '0;
    res.mem_address = vaddr_cur[MemAddrBits-1:0];
    port_step = ctrl_reg[2] ? DataIncRow : DataIncOne;
    // Scroll steps and copies only act while background or sprites are on.
    rendering = mask_reg[3] | mask_reg[4];
    case (ev.action)
      ACT_REG_WRITE: begin
        case (ev.reg_index)
          REG_CONTROL: begin
            ctrl_reg = ev.write_data;
            vaddr_tmp[11:10] = ev.write_data[1:0];
          end
          REG_MASK: mask_reg = ev.write_data;
          REG_SCROLL: begin
            if (!wr_toggle) begin
              fine_x = ev.write_data[2:0];
              vaddr_tmp[4:0] = ev.write_data[7:3];
            end else begin
              vaddr_tmp[14:12] = ev.write_data[2:0];
              vaddr_tmp[9:5] = ev.write_data[7:3];
            end
            wr_toggle = ~wr_toggle;
          end
          REG_ADDRESS: begin
            // The high byte write also clears the two top bits.
            if (!wr_toggle) begin
              vaddr_tmp[15:8] = {2'b00, ev.write_data[5:0]};
            end else begin
              vaddr_tmp[7:0] = ev.write_data;
              vaddr_cur = vaddr_tmp;
            end
            wr_toggle = ~wr_toggle;
          end
          REG_DATA: begin
            res.mem_write = 1'b1;
            res.mem_write_data = ev.write_data;
            vaddr_cur = vaddr_cur + port_step;
          end
          default: ;
        endcase
      end
      ACT_REG_READ: begin
        if (ev.reg_index == REG_STATUS) begin
          res.read_data = {vblank_flag, 2'b00, read_buf[4:0]};
          vblank_flag = 1'b0;
          wr_toggle = 1'b0;
        end else if (ev.reg_index == REG_DATA) begin
          // Palette reads bypass the one-byte read delay.
          res.read_data = (vaddr_cur[13:8] == PaletteHigh) ? ev.vram_read_data : read_buf;
          read_buf = ev.vram_read_data;
          res.mem_read = 1'b1;
          vaddr_cur = vaddr_cur + port_step;
        end
      end
      ACT_INC_X: begin
        if (rendering) begin
          if (vaddr_cur[4:0] == CoarseMax) begin
            vaddr_cur[4:0] = '0;
            vaddr_cur[10] = ~vaddr_cur[10];
          end else begin
            vaddr_cur[4:0] = vaddr_cur[4:0] + 5'd1;
          end
        end
      end
      ACT_INC_Y: begin
        if (rendering) begin
          if (vaddr_cur[14:12] != FineYMax) begin
            vaddr_cur = vaddr_cur + FineYStep;
          end else begin
            // Row 29 is the last visible one and flips the nametable; row 31
            // wraps without a flip.
            vaddr_cur[14:12] = '0;
            cy = vaddr_cur[9:5];
            if (cy == CoarseYLast) begin
              cy = '0;
              vaddr_cur[11] = ~vaddr_cur[11];
            end else if (cy == CoarseMax) begin
              cy = '0;
            end else begin
              cy = cy + 5'd1;
            end
            vaddr_cur[9:5] = cy;
          end
        end
      end
      ACT_COPY_H: begin
        if (rendering) vaddr_cur = (vaddr_cur & 16'hFBE0) | (vaddr_tmp & 16'h041F);
      end
      ACT_COPY_V: begin
        if (rendering) vaddr_cur = (vaddr_cur & 16'h841F) | (vaddr_tmp & 16'h7BE0);
      end
      ACT_VBLANK: begin
        vblank_flag = 1'b1;
        res.nmi_pulse = ctrl_reg[7];
      end
      default: vblank_flag = 1'b0;
    endcase
    res.fine_x_scroll = fine_x;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic push_event(action_e act, reg_e idx, logic [7:0] wd, logic [7:0] vram);
    psaru_in_t ev;
    ev.action = act;
    ev.reg_index = idx;
    ev.write_data = wd;
    ev.vram_read_data = vram;
    event_q.push_back(ev);
    events_queued++;
  endtask

  task automatic push_status_read();
    push_event(ACT_REG_READ, REG_STATUS, 8'($urandom), 8'($urandom));
  endtask

  task automatic push_data_access();
    if ($urandom_range(1)) begin
      push_event(ACT_REG_READ, REG_DATA, 8'($urandom), 8'($urandom));
    end else begin
      push_event(ACT_REG_WRITE, REG_DATA, 8'($urandom), 8'($urandom));
    end
  endtask

  // Queues one short, mostly well-formed program fragment with random
  // content. Two-write sequences usually start with a status read so the
  // write toggle is known; a fifth or so of the fragments are pure noise.
  task automatic push_fragment();
    logic [7:0]  hi;
    logic [7:0]  wd;
    int unsigned n;
    case ($urandom_range(9))
      0: push_event(ACT_REG_WRITE, REG_CONTROL, 8'($urandom), 8'($urandom));
      1: begin
        wd = 8'($urandom);
        if ($urandom_range(4) != 0) wd[4:3] = 2'($urandom_range(1, 3));
        push_event(ACT_REG_WRITE, REG_MASK, wd, 8'($urandom));
      end
      2: begin
        // Point the data port near the palette, a nametable or anywhere.
        case ($urandom_range(3))
          0: hi = 8'h3F;
          1: hi = 8'h3E;
          2: hi = 8'($urandom_range(8'h20, 8'h2F));
          default: hi = 8'($urandom);
        endcase
        if ($urandom_range(4) != 0) push_status_read();
        push_event(ACT_REG_WRITE, REG_ADDRESS, hi, 8'($urandom));
        push_event(ACT_REG_WRITE, REG_ADDRESS, 8'($urandom), 8'($urandom));
        n = $urandom_range(1, 6);
        repeat (n) push_data_access();
      end
      3: begin
        if ($urandom_range(4) != 0) push_status_read();
        push_event(ACT_REG_WRITE, REG_SCROLL, 8'($urandom), 8'($urandom));
        push_event(ACT_REG_WRITE, REG_SCROLL, 8'($urandom), 8'($urandom));
      end
      4: begin
        n = $urandom_range(4, 16);
        repeat (n) begin
          push_event(action_e'($urandom_range(ACT_INC_X, ACT_COPY_V)), reg_e'($urandom),
                     8'($urandom), 8'($urandom));
        end
      end
      5: begin
        // Park fine Y at 7 and coarse Y on a row from 28 to 31, then step Y.
        push_status_read();
        push_event(ACT_REG_WRITE, REG_SCROLL, 8'($urandom), 8'($urandom));
        wd = {5'($urandom_range(28, 31)), 3'd7};
        push_event(ACT_REG_WRITE, REG_SCROLL, wd, 8'($urandom));
        push_event(ACT_COPY_V, reg_e'($urandom), 8'($urandom), 8'($urandom));
        n = $urandom_range(1, 3);
        repeat (n) push_event(ACT_INC_Y, reg_e'($urandom), 8'($urandom), 8'($urandom));
      end
      6: begin
        push_event(ACT_VBLANK, reg_e'($urandom), 8'($urandom), 8'($urandom));
        n = $urandom_range(0, 2);
        repeat (n) push_status_read();
        push_event(ACT_PRERENDER, reg_e'($urandom), 8'($urandom), 8'($urandom));
      end
      7: begin
        n = $urandom_range(2, 8);
        repeat (n) push_data_access();
      end
      default: begin
        push_event(action_e'($urandom), reg_e'($urandom), 8'($urandom), 8'($urandom));
      end
    endcase
  endtask

  // Sets the traffic shape, queues about count events, and waits for every
  // result to come back before returning.
  task automatic run_phase(phase_e p, int unsigned count);
    @(negedge clk_i);
    phase = p;
    send_idle_pct = (p == PH_SEND_IDLE) ? 72 : (p == PH_BOTH) ? 21 : 0;
    recv_stall_pct = (p == PH_RECV_STALL) ? 72 : (p == PH_BOTH) ? 21 : 0;
    events_queued = 0;
    while (events_queued < count) push_fragment();
    while (event_q.size() != 0 || in_valid_i || result_q.size() != 0) @(negedge clk_i);
  endtask

  // Driver: offers the next queued event unless the phase calls for a gap.
  // Valid and payload only change when nothing is offered or the current
  // transfer completes at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i <= event_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or in the pressure phase a long hold-off that
  // lets the pipeline fill and push back on the input side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_count <= 0;
    end else if (phase == PH_PRESSURE) begin
      hold_count <= (hold_count == HoldPeriod - 1) ? 0 : hold_count + 1;
      out_ready_i <= (hold_count >= HoldOff);
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts each input transfer first, then checks any result
  // transfer against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    psaru_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) result_q.push_back(predict_event(in_item_i));
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result transfer with no event outstanding");
        end else begin
          want = result_q.pop_front();
          check_field("read_data", out_item_o.read_data, want.read_data);
          check_field("mem_address", out_item_o.mem_address, want.mem_address);
          check_field("mem_write", out_item_o.mem_write, want.mem_write);
          check_field("mem_write_data", out_item_o.mem_write_data, want.mem_write_data);
          check_field("mem_read", out_item_o.mem_read, want.mem_read);
          check_field("nmi_pulse", out_item_o.nmi_pulse, want.nmi_pulse);
          check_field("fine_x_scroll", out_item_o.fine_x_scroll, want.fine_x_scroll);
        end
      end
    end
  end

  // Watchdog: work is outstanding but neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni && (event_q.size() != 0 || in_valid_i || result_q.size() != 0) &&
        !(in_valid_i && in_ready_o) && !(out_valid_o && out_ready_i)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= StallLimit) begin
        $display("Watchdog: no transfer in %0d cycles", StallLimit);
        $display("Mismatches found");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening: the rendering gate while off, reads that return
    // nothing, ignored writes, NMI on vblank, the status read, palette and
    // buffered data reads, data writes, the scroll pair at its extremes,
    // copies, coarse X and coarse Y wrap at 31, and the pre-render clear.
    push_event(ACT_INC_X, REG_DATA, 8'hFF, 8'hFF);
    push_event(ACT_REG_READ, REG_CONTROL, 8'h00, 8'hFF);
    push_event(ACT_REG_WRITE, REG_STATUS, 8'hFF, 8'h00);
    push_event(ACT_REG_WRITE, REG_OAM_ADDR, 8'hFF, 8'h00);
    push_event(ACT_REG_WRITE, REG_OAM_DATA, 8'h00, 8'hFF);
    push_event(ACT_REG_WRITE, REG_CONTROL, 8'hFF, 8'h00);
    push_event(ACT_VBLANK, REG_CONTROL, 8'h00, 8'h00);
    push_event(ACT_REG_READ, REG_STATUS, 8'h00, 8'h00);
    push_event(ACT_REG_WRITE, REG_ADDRESS, 8'hFF, 8'h00);
    push_event(ACT_REG_WRITE, REG_ADDRESS, 8'h00, 8'h00);
    push_event(ACT_REG_READ, REG_DATA, 8'h00, 8'hAB);
    push_event(ACT_REG_WRITE, REG_ADDRESS, 8'h3E, 8'h00);
    push_event(ACT_REG_WRITE, REG_ADDRESS, 8'hFF, 8'h00);
    push_event(ACT_REG_READ, REG_DATA, 8'h00, 8'h00);
    push_event(ACT_REG_WRITE, REG_DATA, 8'hFF, 8'h00);
    push_event(ACT_REG_WRITE, REG_CONTROL, 8'h00, 8'h00);
    push_event(ACT_REG_WRITE, REG_MASK, 8'h18, 8'h00);
    push_event(ACT_REG_WRITE, REG_SCROLL, 8'hFF, 8'h00);
    push_event(ACT_REG_WRITE, REG_SCROLL, 8'hFF, 8'h00);
    push_event(ACT_COPY_H, REG_CONTROL, 8'h00, 8'h00);
    push_event(ACT_COPY_V, REG_CONTROL, 8'h00, 8'h00);
    push_event(ACT_INC_X, REG_CONTROL, 8'h00, 8'h00);
    push_event(ACT_INC_Y, REG_CONTROL, 8'h00, 8'h00);
    push_event(ACT_PRERENDER, REG_DATA, 8'hFF, 8'hFF);
    push_event(ACT_REG_READ, REG_STATUS, 8'hFF, 8'hFF);

    // Random traffic under each shape, including the back-pressure phase.
    run_phase(PH_STEADY, 230);
    run_phase(PH_SEND_IDLE, 230);
    run_phase(PH_RECV_STALL, 230);
    run_phase(PH_PRESSURE, 160);
    run_phase(PH_BOTH, 230);

    // Catch any stray result that shows up after the last expected one.
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
